/* sv/pbpr_pkg.sv */
// Package for the pooled byte pipe rings block.
// Holds item codes, status codes, default sizes and the channel payload types.
// Depends on nothing.
`timescale 1ns / 1ps

package pbpr_pkg;

  localparam int NUM_PIPES_DEF  = 8;
  localparam int RING_BYTES_DEF = 256;
  localparam int MAX_READ_DEF   = 64;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_ADD   = 3'd1;
  localparam logic [2:0] KIND_DROP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BLOCK   = 3'd1;
  localparam logic [2:0] ST_EOF     = 3'd2;
  localparam logic [2:0] ST_BROKEN  = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;
  localparam logic [2:0] ST_NONE    = 3'd5;

  localparam logic [7:0] END_MAX = 8'd255;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] pipe_index;
    logic       writer_end;
    logic [7:0] data_byte;
    logic [6:0] request_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic [2:0] granted_pipe;
    logic       last_of_run;
  } out_item_t;

endpackage

/* sv/pooled_byte_pipe_rings.sv */
// Top level of the pooled byte pipe rings block.
// Depends on pbpr_pkg for codes and payload types and on pbpr_ring for byte storage.
//
// Usage: items enter on the in_ valid/ready channel, one transaction per item, and
// results leave on the out_ valid/ready channel through an output register.
// The block works on one item at a time. in_ready is high only while no item is in
// progress. The accepting edge reads the pipe descriptor from the descriptor memory,
// and in the update state it is modified and written back once the output register is
// free. Allocate, add, drop, write and every single-result read load their result
// into the output register in the same cycle as that write-back.
// A read that delivers n bytes streams them from the ring memory one per cycle while
// the receiver does not stall. Each byte passes the memory read register and then the
// output register; the stream starts once the descriptor has been written back.
// last_of_run marks the final result of each item.
// When the receiver stalls, the output register holds its transaction and the ring
// stream pauses with one byte parked in the memory read register.
// Reset frees every pipe at once through per-pipe busy flops; there is no clearing
// pass, and the block accepts items in the first cycle after reset.
`timescale 1ns / 1ps

module pooled_byte_pipe_rings #(
  parameter int NUM_PIPES  = pbpr_pkg::NUM_PIPES_DEF,
  parameter int RING_BYTES = pbpr_pkg::RING_BYTES_DEF,
  parameter int MAX_READ   = pbpr_pkg::MAX_READ_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pbpr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pbpr_pkg::out_item_t out_data
);

  import pbpr_pkg::*;

  localparam int PW  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int HW  = $clog2(RING_BYTES);
  localparam int FW  = $clog2(RING_BYTES + 1);
  localparam int AW  = $clog2(NUM_PIPES * RING_BYTES);
  localparam int SW  = ((HW + 1) > 8) ? (HW + 1) : 8;
  localparam int CW  = (FW > 7) ? FW : 7;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [FW-1:0] fill;
    logic [7:0]    rcnt;
    logic [7:0]    wcnt;
  } desc_t;

  logic [1:0]           state_r, state_nxt;
  in_item_t             item_r;
  desc_t                desc_mem [NUM_PIPES];
  desc_t                desc_q_r;
  logic [NUM_PIPES-1:0] busy_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;
  logic [HW-1:0]        pos_r;
  logic [6:0]           rem_r;
  logic                 pend_r;
  logic                 pend_last_r;
  logic [AW-1:0]        base_r;

  logic                 in_acc;
  logic [PW+2:0]        in_idx_ext;
  logic [PW-1:0]        in_pidx;
  logic [PW+2:0]        idx_ext;
  logic [PW-1:0]        pidx;
  logic                 in_range;
  logic                 busy_p;
  logic                 out_free;
  logic                 go;
  logic [PW-1:0]        grant;
  logic                 found;
  logic [PW+2:0]        grant_ext;
  logic [6:0]           len_c;
  logic [6:0]           n_rd;
  logic [SW-1:0]        tsum;
  logic [HW-1:0]        tail;
  logic [SW-1:0]        hsum;
  logic [HW-1:0]        head_new;
  logic [7:0]           cnt_sel;
  logic [7:0]           cnt_new;
  logic [AW-1:0]        pipe_base;
  out_item_t            res;
  logic                 res_load;
  logic                 desc_we;
  logic [PW-1:0]        desc_waddr;
  desc_t                desc_wdata;
  logic                 busy_set;
  logic                 busy_clr;
  logic                 ring_we;
  logic [AW-1:0]        ring_waddr;
  logic                 start_stream;
  logic                 move;
  logic                 issue;
  logic                 stream_done;
  logic [AW-1:0]        ring_raddr;
  logic [7:0]           ring_rdata;
  logic [HW-1:0]        pos_inc;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign in_idx_ext = {{PW{1'b0}}, in_data.pipe_index};
  assign in_pidx    = in_idx_ext[PW-1:0];
  assign idx_ext    = {{PW{1'b0}}, item_r.pipe_index};
  assign pidx       = idx_ext[PW-1:0];
  assign in_range   = ({29'd0, item_r.pipe_index} < 32'(NUM_PIPES));
  assign busy_p     = in_range && busy_r[pidx];
  assign out_free   = !out_valid_r || out_ready;
  assign go         = (state_r == S_EXEC) && out_free;
  assign pipe_base  = AW'(pidx) * AW'(RING_BYTES);

  always_comb begin
    grant = '0;
    found = 1'b0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        grant = PW'(i);
        found = 1'b1;
      end
    end
  end

  assign grant_ext = {3'd0, grant};

  always_comb begin
    len_c = item_r.request_length;
    if (len_c == 7'd0) begin
      len_c = 7'd1;
    end else if (len_c > 7'(MAX_READ)) begin
      len_c = 7'(MAX_READ);
    end
    n_rd = (CW'(desc_q_r.fill) < CW'(len_c)) ? 7'(desc_q_r.fill) : len_c;
  end

  always_comb begin
    tsum = SW'(desc_q_r.head) + SW'(desc_q_r.fill);
    if (tsum >= SW'(RING_BYTES)) begin
      tsum = tsum - SW'(RING_BYTES);
    end
    tail = tsum[HW-1:0];
    hsum = SW'(desc_q_r.head) + SW'(n_rd);
    if (hsum >= SW'(RING_BYTES)) begin
      hsum = hsum - SW'(RING_BYTES);
    end
    head_new = hsum[HW-1:0];
  end

  assign cnt_sel = item_r.writer_end ? desc_q_r.wcnt : desc_q_r.rcnt;

  always_comb begin
    res          = '{status: ST_OK, read_byte: 8'd0, granted_pipe: 3'd0, last_of_run: 1'b1};
    res_load     = go;
    desc_we      = 1'b0;
    desc_waddr   = pidx;
    desc_wdata   = desc_q_r;
    busy_set     = 1'b0;
    busy_clr     = 1'b0;
    ring_we      = 1'b0;
    start_stream = 1'b0;
    cnt_new      = cnt_sel;
    if (item_r.kind == KIND_ALLOC) begin
      if (found) begin
        desc_we          = go;
        desc_waddr       = grant;
        desc_wdata       = '0;
        busy_set         = go;
        res.granted_pipe = grant_ext[2:0];
      end else begin
        res.status = ST_NONE;
      end
    end else if ((item_r.kind > KIND_READ) || !busy_p) begin
      res.status = ST_INVALID;
    end else begin
      unique case (item_r.kind)
        KIND_ADD: begin
          if (cnt_sel != END_MAX) begin
            cnt_new = cnt_sel + 8'd1;
          end
          if (item_r.writer_end) begin
            desc_wdata.wcnt = cnt_new;
          end else begin
            desc_wdata.rcnt = cnt_new;
          end
          desc_we = go;
        end
        KIND_DROP: begin
          if (cnt_sel != 8'd0) begin
            cnt_new = cnt_sel - 8'd1;
          end
          if (item_r.writer_end) begin
            desc_wdata.wcnt = cnt_new;
          end else begin
            desc_wdata.rcnt = cnt_new;
          end
          if ((desc_wdata.wcnt == 8'd0) && (desc_wdata.rcnt == 8'd0)) begin
            desc_wdata.head = '0;
            desc_wdata.fill = '0;
            busy_clr        = go;
          end
          desc_we = go;
        end
        KIND_WRITE: begin
          if (desc_q_r.rcnt == 8'd0) begin
            res.status = ST_BROKEN;
          end else if (desc_q_r.fill == FW'(RING_BYTES)) begin
            res.status = ST_BLOCK;
          end else begin
            desc_wdata.fill = desc_q_r.fill + FW'(1);
            desc_we         = go;
            ring_we         = go;
          end
        end
        KIND_READ: begin
          if (desc_q_r.fill == '0) begin
            res.status = (desc_q_r.wcnt != 8'd0) ? ST_BLOCK : ST_EOF;
          end else begin
            desc_wdata.head = head_new;
            desc_wdata.fill = desc_q_r.fill - FW'(n_rd);
            desc_we         = go;
            res_load        = 1'b0;
            start_stream    = go;
          end
        end
        default: begin
          res.status = ST_INVALID;
        end
      endcase
    end
  end

  assign ring_waddr = pipe_base + AW'(tail);

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_waddr] <= desc_wdata;
    end
    if (in_acc) begin
      desc_q_r <= desc_mem[in_pidx];
      item_r   <= in_data;
    end
  end

  assign move        = pend_r && out_free;
  assign issue       = (state_r == S_STREAM) && (rem_r != 7'd0) && (!pend_r || move);
  assign stream_done = (state_r == S_STREAM) && (rem_r == 7'd0) && (!pend_r || move);
  assign ring_raddr  = base_r + AW'(pos_r);
  assign pos_inc     = (SW'(pos_r) + SW'(1) == SW'(RING_BYTES)) ? '0 : pos_r + HW'(1);

  pbpr_ring #(
    .DEPTH (NUM_PIPES * RING_BYTES),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (item_r.data_byte),
    .rd_en   (issue),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (start_stream) begin
          state_nxt = S_STREAM;
        end else if (go) begin
          state_nxt = S_IDLE;
        end
      end
      S_STREAM: begin
        if (stream_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      rem_r       <= 7'd0;
    end else begin
      state_r <= state_nxt;
      if (busy_set) begin
        busy_r[grant] <= 1'b1;
      end
      if (busy_clr) begin
        busy_r[pidx] <= 1'b0;
      end
      if (res_load || move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (start_stream) begin
        rem_r  <= n_rd;
        pend_r <= 1'b0;
      end else begin
        if (issue) begin
          rem_r  <= rem_r - 7'd1;
          pend_r <= 1'b1;
        end else if (move) begin
          pend_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end else if (move) begin
      out_data_r <= '{status: ST_OK, read_byte: ring_rdata, granted_pipe: 3'd0,
                      last_of_run: pend_last_r};
    end
    if (start_stream) begin
      pos_r  <= desc_q_r.head;
      base_r <= pipe_base;
    end else if (issue) begin
      pos_r <= pos_inc;
    end
    if (issue) begin
      pend_last_r <= (rem_r == 7'd1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC))
    else $error("accepted transaction did not move to descriptor update");

  a_idle_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!pend_r && (rem_r == 7'd0)))
    else $error("input accepted while a read stream is unfinished");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    desc_we |-> (int'(desc_wdata.fill) <= RING_BYTES))
    else $error("fill count written beyond ring size");

  a_byte_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.read_byte == 8'd0))
    else $error("non-ok result carries a data byte");

endmodule

/* sv/pbpr_ring.sv */
// Byte store shared by all rings of the pipe pool.
// One write port and one read port with registered read data; no dependencies.
`timescale 1ns / 1ps

module pbpr_ring #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
